@@ hdl/softmax_vector_normalizer_core_assert.svh @@
// Assertion macros used by the checker file
`ifndef SOFTMAX_VECTOR_NORMALIZER_CORE_ASSERT_SVH
`define SOFTMAX_VECTOR_NORMALIZER_CORE_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define SVN_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a stalled item holds its payload in the next cycle
`define SVN_ASSERT_HOLD(label, clk, rst_n, vld, stl, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

@@ hdl/svn_pkg.sv @@
package svn_pkg;

    localparam int LOGIT_W = 16;
    localparam int EXP_W   = 32;
    localparam int SUM_W   = 38;
    localparam int PROB_W  = 16;
    localparam int LEN_W   = 7;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] C1_Q16    = 16'd43025;
    localparam logic [14:0] C2_Q16    = 15'd22511;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DIV,
        BK_OUT
    } bk_state_t;

    // Command from the front end to the back end
    typedef struct packed {
        logic [LEN_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } vec_cmd_t;

endpackage

@@ hdl/svn_ram.sv @@
module svn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/svn_front.sv @@
module svn_front #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [svn_pkg::LOGIT_W-1:0]       logit,
    input  logic [svn_pkg::LEN_W-1:0]         vector_length,
    output logic                              wr_en,
    output logic [$clog2(MAX_LENGTH)-1:0]     wr_addr,
    output logic [svn_pkg::EXP_W-1:0]         wr_data,
    output logic                              cmd_valid,
    input  logic                              cmd_stall,
    output svn_pkg::vec_cmd_t                 cmd
);
    import svn_pkg::*;

    localparam int AW = $clog2(MAX_LENGTH);
    localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LENGTH);

    // Stage 1: product of logit and log2(e)
    logic              s1_vld_reg;
    logic signed [33:0] s1_t_reg;
    // Stage 2: mantissa terms
    logic              s2_vld_reg;
    logic signed [5:0] s2_n_reg;
    logic [15:0]       s2_f_reg;
    logic [31:0]       s2_ff_reg;
    // Stage 3: mantissa products
    logic              s3_vld_reg;
    logic signed [5:0] s3_n_reg;
    logic [16:0]       s3_lin_reg;
    logic [15:0]       s3_sq_reg;

    logic [LEN_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              busy;
    logic              pend_reg;

    // Front pipeline runs one item at a time while the back end owns the store
    assign busy     = s1_vld_reg | s2_vld_reg | s3_vld_reg | pend_reg;
    assign in_stall = busy | cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_valid & ~in_stall;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Advance the exponent pipeline
    always_ff @(posedge clk)
    begin
        s1_t_reg   <= $signed(logit) * $signed({1'b0, LOG2E_Q16});
        s2_n_reg   <= s1_t_reg[33:28];
        s2_f_reg   <= s1_t_reg[27:12];
        s2_ff_reg  <= s1_t_reg[27:12] * s1_t_reg[27:12];
        s3_n_reg   <= s2_n_reg;
        s3_lin_reg <= 17'((32'(s2_f_reg) * C1_Q16) >> 16);
        s3_sq_reg  <= 16'((48'(s2_ff_reg) * C2_Q16) >> 32);
    end

    // Scale mantissa by 2^(n+4) with saturation
    logic [17:0]       mant;
    logic signed [6:0] sh;
    logic [63:0]       wide;
    logic [EXP_W-1:0]  exp_val;
    always_comb
    begin
        mant = 18'd65536 + 18'(s3_lin_reg) + 18'(s3_sq_reg);
        sh   = 7'(s3_n_reg) + 7'sd4;
        wide = '0;
        if (sh >= 0)
        begin
            wide = 64'(mant) << sh[4:0];
        end
        else
        begin
            wide = 64'(mant) >> 7'(-sh);
        end
        if (sh > 7'sd31 || wide[63:32] != '0)
        begin
            exp_val = '1;
        end
        else
        begin
            exp_val = wide[31:0];
        end
    end

    logic [LEN_W-1:0] eff_len;
    always_comb
    begin
        if (vector_length == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (vector_length > MAX_L)
        begin
            eff_len = MAX_L;
        end
        else
        begin
            eff_len = vector_length;
        end
    end

    logic do_store;
    logic done;
    assign do_store = s3_vld_reg && (count_reg < MAX_L);
    assign wr_en    = do_store;
    assign wr_addr  = count_reg[AW-1:0];
    assign wr_data  = exp_val;

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (do_store)
        begin
            count_next = count_reg + LEN_W'(1);
            sum_next   = sum_reg + SUM_W'(exp_val);
        end
        done = s3_vld_reg && (count_next >= eff_len);
    end

    // Hold a finished vector until the back end takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else if (done)
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            pend_reg  <= 1'b1;
        end
        else if (pend_reg && !cmd_stall)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign cmd_valid = pend_reg;
    assign cmd.count = count_reg;
    assign cmd.sum   = sum_reg;

endmodule

@@ hdl/svn_back.sv @@
module svn_back #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  svn_pkg::vec_cmd_t             cmd,
    output logic [$clog2(MAX_LENGTH)-1:0] rd_addr,
    input  logic [svn_pkg::EXP_W-1:0]     rd_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [svn_pkg::PROB_W-1:0]    probability,
    output logic                          last_of_vector
);
    import svn_pkg::*;

    localparam int AW   = $clog2(MAX_LENGTH);
    localparam int NUMW = EXP_W + 16;
    localparam int QW   = 17;

    bk_state_t        state_reg, state_next;
    vec_cmd_t         cmd_reg;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [SUM_W:0]   rem_reg, rem_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [4:0]       bit_reg, bit_next;
    logic [NUMW-1:0]  num_reg, num_next;
    logic             take;

    // Address the store with the next index so the registered read lines up
    assign take      = (state_reg == BK_IDLE) && cmd_valid;
    assign cmd_stall = (state_reg != BK_IDLE);
    assign rd_addr   = idx_next[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        bit_reg <= bit_next;
        num_reg <= num_next;
    end

    // Restoring division, one quotient bit a cycle (quotient capped at 17 bits)
    logic [SUM_W:0] trial;
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        num_next   = num_reg;
        trial      = '0;
        case (state_reg)
            BK_IDLE:
            begin
                idx_next = '0;
                if (cmd_valid)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_DIV;
                num_next   = {rd_data, 16'd0};
                rem_next   = (SUM_W+1)'({rd_data, 16'd0} >> QW);
                q_next     = '0;
                bit_next   = 5'(QW - 1);
            end
            BK_DIV:
            begin
                trial = {rem_reg[SUM_W-1:0], num_reg[bit_reg]};
                if (trial >= {1'b0, cmd_reg.sum})
                begin
                    rem_next = trial - {1'b0, cmd_reg.sum};
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[QW-2:0], 1'b0};
                end
                if (bit_reg == '0)
                begin
                    state_next = BK_OUT;
                end
                else
                begin
                    bit_next = bit_reg - 5'd1;
                end
            end
            BK_OUT:
            begin
                if (!out_stall)
                begin
                    if (idx_reg + LEN_W'(1) >= cmd_reg.count)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Saturate when the top quotient bit is set; a zero sum gives zero
    logic over;
    assign over = (rem_reg == '0) ? 1'b0 : 1'b0;
    assign out_valid      = (state_reg == BK_OUT);
    assign probability    = (cmd_reg.sum == '0) ? '0 :
                            (q_reg[QW-1] || over) ? 16'hFFFF : q_reg[15:0];
    assign last_of_vector = (idx_reg + LEN_W'(1) >= cmd_reg.count);

endmodule

@@ hdl/softmax_vector_normalizer_core.sv @@
// Flow: an accepted item passes stages s1, s2 and s3 and is then written to the
//   store; once a vector is complete, the back end reads, divides and raises
//   out_valid for its first result. The front end takes one item at a time and
//   holds input off while the back end drains the store; each result takes a store
//   read, the 17-step restoring divider and output, plus any output stall.
// Reset: rst_n clears count, sum and sequencers; vector_length returns to 64.
module softmax_vector_normalizer_core #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [svn_pkg::LOGIT_W-1:0]    logit,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [svn_pkg::PROB_W-1:0]     probability,
    output logic                           last_of_vector,
    input  logic                           cfg_we,
    input  logic [svn_pkg::LEN_W-1:0]      cfg_wdata
);
    import svn_pkg::*;

    localparam int AW = $clog2(MAX_LENGTH);

    logic [LEN_W-1:0] vlen_reg;
    logic             wr_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [EXP_W-1:0] wr_data, rd_data;
    logic             cmd_valid, cmd_stall;
    vec_cmd_t         cmd;

    // Hold the vector length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= LEN_W'(64);
        end
        else if (cfg_we)
        begin
            vlen_reg <= cfg_wdata;
        end
    end

    svn_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .logit,
        .vector_length(vlen_reg),
        .wr_en, .wr_addr, .wr_data, .cmd_valid, .cmd_stall, .cmd
    );

    svn_ram #(.WIDTH(EXP_W), .DEPTH(MAX_LENGTH)) u_store (
        .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
        .raddr(rd_addr), .rdata(rd_data)
    );

    svn_back #(.MAX_LENGTH(MAX_LENGTH)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_stall, .cmd, .rd_addr, .rd_data,
        .out_valid, .out_stall, .probability, .last_of_vector
    );

endmodule

@@ hdl/svn_checker.sv @@
`include "softmax_vector_normalizer_core_assert.svh"

module svn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] probability,
    input logic        last_of_vector
);

    `SVN_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_stall, probability, "output moved")
    `SVN_ASSERT_HOLD(a_last_hold, clk, rst_n, out_valid, out_stall, last_of_vector, "last moved")
    `SVN_ASSERT_IMPL(a_accept_stall, clk, rst_n, $past(in_valid && !in_stall) |-> in_stall, "accept gap")
    `SVN_ASSERT_IMPL(a_last_drop, clk, rst_n, (out_valid && !out_stall && last_of_vector) |=> !out_valid, "ran past last")

endmodule

bind softmax_vector_normalizer_core svn_checker u_svn_checker (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .probability, .last_of_vector
);
